FILE: hw/rtl/ekvp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ekvp_pkg;

    localparam int CHAR_W  = 8;
    localparam int KLIM_W  = 7;
    localparam int VLIM_W  = 12;
    localparam int CFG_W   = 12;
    localparam int CFG_IDX_W = 1;
    localparam int SLOTS   = 3;

    localparam logic [KLIM_W-1:0] KEY_LIMIT_RESET   = 7'd127;
    localparam logic [VLIM_W-1:0] VALUE_LIMIT_RESET = 12'd4095;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LIMIT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_LIMIT = 1'b1;

    localparam logic [7:0] CH_END   = 8'h00;
    localparam logic [7:0] CH_ESC   = 8'h5C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    typedef enum logic [1:0] {
        KIND_KEY     = 2'd0,
        KIND_VALUE   = 2'd1,
        KIND_PAIR    = 2'd2,
        KIND_VERDICT = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        VERD_EMPTY     = 2'd0,
        VERD_VALID     = 2'd1,
        VERD_OVERFLOW  = 2'd2,
        VERD_MALFORMED = 2'd3
    } verd_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  ch;
        verd_t       verd;
    } result_t;

    typedef struct packed {
        logic [1:0]          count;
        result_t [SLOTS-1:0] slot;
    } bundle_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ekvp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ekvp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface ekvp_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] item_kind;
    logic [7:0] out_char;
    logic [1:0] verdict;
    logic       run_last;

    modport source (output valid, output item_kind, output out_char, output verdict,
                    output run_last, input ready);
    modport sink   (input valid, input item_kind, input out_char, input verdict,
                    input run_last, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/ekvp_parse.sv
`timescale 1ns / 1ps
`default_nettype none
module ekvp_parse (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           take,
    input  wire logic [7:0]                     char_code,
    input  wire logic                           cfg_we,
    input  wire logic [ekvp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ekvp_pkg::CFG_W-1:0]     cfg_data,
    output ekvp_pkg::bundle_t                   bund
);
    import ekvp_pkg::*;

    typedef enum logic [1:0] {
        PH_SKIP  = 2'd0,
        PH_KEY   = 2'd1,
        PH_VALUE = 2'd2,
        PH_DONE  = 2'd3
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic                esc_reg, esc_next;
    logic [KLIM_W-1:0]   kcnt_reg, kcnt_next;
    logic [VLIM_W-1:0]   vcnt_reg, vcnt_next;
    logic                pair_reg, pair_next;
    logic [KLIM_W-1:0]   klim_reg;
    logic [VLIM_W-1:0]   vlim_reg;

    logic                is_ws;
    logic                is_end;
    logic                is_term;

    assign is_ws   = (char_code inside {[8'd9:8'd13], 8'd32});
    assign is_end  = (char_code == CH_END);
    assign is_term = is_end || (char_code == CH_SEMI);

    always_comb
    begin
        logic [1:0] n;
        logic       in_key;
        logic       fin;
        verd_t      fin_v;

        n          = 2'd0;
        fin        = 1'b0;
        fin_v      = VERD_EMPTY;
        in_key     = 1'b0;
        phase_next = phase_reg;
        esc_next   = esc_reg;
        kcnt_next  = kcnt_reg;
        vcnt_next  = vcnt_reg;
        pair_next  = pair_reg;
        bund       = '0;

        case (phase_reg)
            PH_DONE:
            begin
                if (is_end)
                begin
                    phase_next = PH_SKIP;
                    esc_next   = 1'b0;
                    kcnt_next  = '0;
                    vcnt_next  = '0;
                    pair_next  = 1'b0;
                end
            end
            PH_SKIP:
            begin
                if (is_term)
                begin
                    fin   = 1'b1;
                    fin_v = pair_reg ? VERD_VALID : VERD_EMPTY;
                end
                else if (!is_ws)
                begin
                    in_key    = 1'b1;
                    kcnt_next = '0;
                    esc_next  = 1'b0;
                end
            end
            PH_KEY:
            begin
                in_key = 1'b1;
            end
            PH_VALUE:
            begin
                if (esc_reg)
                begin
                    esc_next = 1'b0;
                    if (is_end)
                    begin
                        bund.slot[n] = '{KIND_VALUE, CH_ESC, VERD_EMPTY};
                        n = n + 2'd1;
                        bund.slot[n] = '{KIND_PAIR, 8'd0, VERD_EMPTY};
                        n = n + 2'd1;
                        fin   = 1'b1;
                        fin_v = VERD_VALID;
                    end
                    else
                    begin
                        bund.slot[n] = '{KIND_VALUE, char_code, VERD_EMPTY};
                        n = n + 2'd1;
                        vcnt_next = vcnt_reg + 1'b1;
                    end
                end
                else if (is_term)
                begin
                    bund.slot[n] = '{KIND_PAIR, 8'd0, VERD_EMPTY};
                    n = n + 2'd1;
                    fin   = 1'b1;
                    fin_v = VERD_VALID;
                end
                else if (char_code == CH_COMMA)
                begin
                    bund.slot[n] = '{KIND_PAIR, 8'd0, VERD_EMPTY};
                    n = n + 2'd1;
                    pair_next  = 1'b1;
                    phase_next = PH_SKIP;
                end
                else if (vcnt_reg >= vlim_reg)
                begin
                    fin   = 1'b1;
                    fin_v = VERD_OVERFLOW;
                end
                else if (char_code == CH_ESC)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    bund.slot[n] = '{KIND_VALUE, char_code, VERD_EMPTY};
                    n = n + 2'd1;
                    vcnt_next = vcnt_reg + 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_SKIP;
            end
        endcase

        // key handling, entered from the key phase or straight out of skip
        if (in_key)
        begin
            phase_next = PH_KEY;
            if (esc_reg && phase_reg == PH_KEY)
            begin
                esc_next = 1'b0;
                if (is_end)
                begin
                    bund.slot[n] = '{KIND_KEY, CH_ESC, VERD_EMPTY};
                    n = n + 2'd1;
                    fin   = 1'b1;
                    fin_v = VERD_MALFORMED;
                end
                else
                begin
                    bund.slot[n] = '{KIND_KEY, char_code, VERD_EMPTY};
                    n = n + 2'd1;
                    kcnt_next = kcnt_reg + 1'b1;
                end
            end
            else if (is_term)
            begin
                fin   = 1'b1;
                fin_v = VERD_MALFORMED;
            end
            else if (char_code == CH_EQ)
            begin
                if (kcnt_next == '0)
                begin
                    fin   = 1'b1;
                    fin_v = VERD_MALFORMED;
                end
                else
                begin
                    phase_next = PH_VALUE;
                    vcnt_next  = '0;
                end
            end
            else if (kcnt_next >= klim_reg)
            begin
                fin   = 1'b1;
                fin_v = VERD_OVERFLOW;
            end
            else if (char_code == CH_ESC)
            begin
                esc_next = 1'b1;
            end
            else
            begin
                bund.slot[n] = '{KIND_KEY, char_code, VERD_EMPTY};
                n = n + 2'd1;
                kcnt_next = kcnt_next + 1'b1;
            end
        end

        if (fin)
        begin
            bund.slot[n] = '{KIND_VERDICT, 8'd0, fin_v};
            n = n + 2'd1;
            esc_next = 1'b0;
            if (is_end)
            begin
                phase_next = PH_SKIP;
                kcnt_next  = '0;
                vcnt_next  = '0;
                pair_next  = 1'b0;
            end
            else
            begin
                phase_next = PH_DONE;
            end
        end

        bund.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            esc_reg   <= 1'b0;
            kcnt_reg  <= '0;
            vcnt_reg  <= '0;
            pair_reg  <= 1'b0;
            klim_reg  <= KEY_LIMIT_RESET;
            vlim_reg  <= VALUE_LIMIT_RESET;
        end
        else
        begin
            if (take)
            begin
                phase_reg <= phase_next;
                esc_reg   <= esc_next;
                kcnt_reg  <= kcnt_next;
                vcnt_reg  <= vcnt_next;
                pair_reg  <= pair_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_KEY_LIMIT:   klim_reg <= cfg_data[KLIM_W-1:0];
                    CFG_VALUE_LIMIT: vlim_reg <= cfg_data[VLIM_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/ekvp_outq.sv
`timescale 1ns / 1ps
`default_nettype none
module ekvp_outq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire ekvp_pkg::bundle_t bund,
    output logic                   room,
    ekvp_item_if.source            items
);
    import ekvp_pkg::*;

    result_t [SLOTS-1:0] slot_reg;
    logic [1:0]          cnt_reg, cnt_next;
    logic [1:0]          pos_reg, pos_next;
    logic                at_last;
    logic                drain;
    result_t             cur;

    assign cur     = slot_reg[pos_reg];
    assign at_last = (pos_reg == cnt_reg - 2'd1);
    assign drain   = items.valid && items.ready;

    // free after this edge if empty or the final result leaves now
    assign room = (cnt_reg == 2'd0) || (drain && at_last);

    assign items.valid     = (cnt_reg != 2'd0);
    assign items.item_kind = cur.kind;
    assign items.out_char  = cur.ch;
    assign items.verdict   = cur.verd;
    assign items.run_last  = at_last;

    always_comb
    begin
        cnt_next = cnt_reg;
        pos_next = pos_reg;
        if (drain)
        begin
            if (at_last)
            begin
                cnt_next = 2'd0;
                pos_next = 2'd0;
            end
            else
            begin
                pos_next = pos_reg + 2'd1;
            end
        end
        if (load && bund.count != 2'd0)
        begin
            cnt_next = bund.count;
            pos_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            pos_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && bund.count != 2'd0)
        begin
            slot_reg <= bund.slot;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/escaped_key_value_list_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// A character's first result is registered and valid the cycle after it is accepted.
// Throughput: one character per cycle while items.ready is high; a character causing k
// results (k up to three) holds the input while the result register drains them.
// Characters causing no result are taken every cycle.
// Reset: asynchronous, active low; parser rearmed, limits at their maximum.
module escaped_key_value_list_parser (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    ekvp_char_if.sink                           chars,
    ekvp_item_if.source                         items,
    input  wire logic                           cfg_we,
    input  wire logic [ekvp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ekvp_pkg::CFG_W-1:0]     cfg_data
);
    import ekvp_pkg::*;

    bundle_t bund;
    logic    room;
    logic    take;

    assign chars.ready = room;
    assign take        = chars.valid && room;

    ekvp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .char_code (chars.char_code),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bund      (bund)
    );

    ekvp_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (take),
        .bund  (bund),
        .room  (room),
        .items (items)
    );

endmodule
`default_nettype wire
